// ===== rtl/qmj_pkg.sv =====
// shared types and constants of the quintic trajectory unit
package qmj_pkg;

	localparam int DW     = 56;  // working width of signed intermediates
	localparam int HW     = 28;  // half of the working width, one multiplier pass
	localparam int BW     = 31;  // unsigned multiplier operand width
	localparam int PW     = 87;  // full product width, DW + BW
	localparam int IW     = 32;  // Q16.16 field width
	localparam int DURW   = 16;  // Q6.10 duration width
	localparam int TW     = 6;   // sample time width
	localparam int FRAC_U = 40;  // quotient bits of t * 2^40 / D
	localparam int STEPW  = 4;   // micro-step counter width

	localparam logic signed [DW-1:0] POS_MAX = DW'(64'sd2147483647);
	localparam logic signed [DW-1:0] POS_MIN = -DW'(64'sd2147483648);

	typedef enum logic [2:0] {
		OPA_A0, OPA_V0, OPA_AT, OPA_DV, OPA_DA, OPA_DAT, OPA_ACC, OPA_C
	} opa_t;

	typedef enum logic [1:0] {
		OPB_DUR, OPB_TIME, OPB_U
	} opb_t;

	typedef enum logic [1:0] {
		RND_NONE, RND_10, RND_11, RND_MQ
	} rmode_t;

	typedef enum logic [2:0] {
		DST_AT, DST_ATT, DST_VT, DST_DVT, DST_DAT, DST_DATT, DST_ACC, DST_P2
	} dst_t;

	typedef enum logic [2:0] {
		ADD_NONE, ADD_A, ADD_B, ADD_2V0, ADD_2S0
	} add_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_FORM_H, ST_FORM_COEF,
		ST_DIV_GO, ST_DIV_WAIT, ST_EMIT
	} state_t;

	typedef struct packed {
		logic   load;
		logic   mul_go;
		opa_t   opa;
		opb_t   opb;
		rmode_t mode;
		dst_t   dst;
		add_t   add;
		logic   form_h;
		logic   form_coef;
		logic   div_go;
		logic   emit;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic out_free;
		logic last_sample;
	} sts_t;

endpackage

// ===== rtl/qmj_mul.sv =====
// two-pass signed by unsigned multiplier with rounding on the way out
module qmj_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  logic signed [qmj_pkg::DW-1:0]   a,
	input  logic        [qmj_pkg::BW-1:0]   b,
	input  qmj_pkg::rmode_t                 mode,
	output logic signed [qmj_pkg::DW-1:0]   res,
	output logic                            done
);

	localparam int DW = qmj_pkg::DW;
	localparam int HW = qmj_pkg::HW;
	localparam int BW = qmj_pkg::BW;
	localparam int PW = qmj_pkg::PW;

	logic [DW-1:0]          mag_q;
	logic                   neg_q;
	logic [BW-1:0]          b_q;
	qmj_pkg::rmode_t        mode_q;
	logic [PW-1:0]          prod_q;
	logic [1:0]             ph_q;
	logic                   busy_q;
	logic                   done_q;
	logic signed [DW-1:0]   res_q;

	logic [PW-1:0]          lo_p;
	logic [PW-1:0]          hi_p;
	logic signed [PW:0]     sprod;
	logic signed [PW:0]     r10;
	logic signed [PW:0]     r11;
	logic [PW-1:0]          mr;
	logic signed [DW-1:0]   fin;

	assign lo_p = PW'(mag_q[HW-1:0]) * PW'(b_q);
	assign hi_p = (PW'(mag_q[DW-1:HW]) * PW'(b_q)) << HW;

	always_comb begin
		sprod = neg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
		r10   = (sprod + (PW+1)'(512)) >>> 10;
		r11   = (sprod + (PW+1)'(1024)) >>> 11;
		mr    = (prod_q + (PW'(1) << 29)) >> 30;
		case (mode_q)
			qmj_pkg::RND_NONE: fin = sprod[DW-1:0];
			qmj_pkg::RND_10:   fin = r10[DW-1:0];
			qmj_pkg::RND_11:   fin = r11[DW-1:0];
			default:           fin = neg_q ? -$signed(mr[DW-1:0]) : $signed(mr[DW-1:0]);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				ph_q   <= 2'd0;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			mag_q  <= (a < 0) ? DW'(-a) : DW'(a);
			neg_q  <= a < 0;
			b_q    <= b;
			mode_q <= mode;
		end else if (busy_q) begin
			case (ph_q)
				2'd0:    prod_q <= lo_p;
				2'd1:    prod_q <= prod_q + hi_p;
				default: res_q  <= fin;
			endcase
		end
	end

	assign res  = res_q;
	assign done = done_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("multiplier flags done while still busy");

endmodule

// ===== rtl/qmj_div.sv =====
// restoring divider for the normalised sample time t * 2^40 / D
module qmj_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  logic [qmj_pkg::TW-1:0]         t,
	input  logic [qmj_pkg::DURW-1:0]       d,
	output logic [qmj_pkg::BW-1:0]         q,
	output logic                           done
);

	localparam int DURW = qmj_pkg::DURW;
	localparam int BW   = qmj_pkg::BW;

	logic [DURW-1:0] rem_q;
	logic [BW-1:0]   q_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DURW:0]   rem2;
	logic            ge;

	// t < D whenever t is nonzero, so the integer part is already the remainder
	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(qmj_pkg::FRAC_U - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= DURW'(t);
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DURW'(rem2 - {1'b0, d}) : rem2[DURW-1:0];
			q_q   <= {q_q[BW-2:0], ge};
		end
	end

	assign q    = q_q;
	assign done = done_q;

endmodule

// ===== rtl/qmj_dp.sv =====
// datapath: operand registers, coefficient solve, sample evaluation, output register
module qmj_dp #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qmj_pkg::cmd_t                cmd,
	output qmj_pkg::sts_t                sts,
	input  logic signed [31:0]           start_pos,
	input  logic signed [31:0]           start_vel,
	input  logic signed [31:0]           start_acc,
	input  logic signed [31:0]           end_pos,
	input  logic signed [31:0]           end_vel,
	input  logic signed [31:0]           end_acc,
	input  logic        [15:0]           duration,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic        [5:0]            sample_time,
	output logic signed [31:0]           position,
	output logic                         last
);

	localparam int DW = qmj_pkg::DW;
	localparam int BW = qmj_pkg::BW;
	localparam int TW = qmj_pkg::TW;
	localparam logic [TW-1:0] LAST_CAP = TW'(MAX_SAMPLES - 1);

	logic signed [31:0] s0_q, v0_q, a0_q, s1_q, v1_q, a1_q;
	logic [15:0]        d_q;
	logic signed [DW-1:0] at_q, att_q, vt_q, dvt_q, dat_q, datt_q;
	logic signed [DW-1:0] h_q, a_q, b_q, c_q, acc_q, p2_q;
	logic [BW-1:0]      u_q;
	logic [TW-1:0]      t_q;
	qmj_pkg::dst_t      dst_q;
	qmj_pkg::add_t      add_q;

	logic               out_valid_q;
	logic [TW-1:0]      out_time_q;
	logic signed [31:0] out_pos_q;
	logic               out_last_q;

	logic signed [DW-1:0] opa;
	logic [BW-1:0]        opb;
	logic signed [DW-1:0] mres;
	logic                 mdone;
	logic [BW-1:0]        dq;
	logic                 ddone;
	logic signed [DW-1:0] addend;
	logic signed [DW-1:0] wres;
	logic signed [DW-1:0] dv, da;
	logic signed [DW-1:0] sum, rsum;
	logic signed [31:0]   pos_sat;
	logic [TW-1:0]        t_last;
	logic                 out_free;

	assign dv = DW'(v1_q) - DW'(v0_q) - at_q;
	assign da = DW'(a1_q) - DW'(a0_q);

	always_comb begin
		case (cmd.opa)
			qmj_pkg::OPA_A0:  opa = DW'(a0_q);
			qmj_pkg::OPA_V0:  opa = DW'(v0_q);
			qmj_pkg::OPA_AT:  opa = at_q;
			qmj_pkg::OPA_DV:  opa = dv;
			qmj_pkg::OPA_DA:  opa = da;
			qmj_pkg::OPA_DAT: opa = dat_q;
			qmj_pkg::OPA_ACC: opa = acc_q;
			default:          opa = c_q;
		endcase
		case (cmd.opb)
			qmj_pkg::OPB_DUR:  opb = BW'(d_q);
			qmj_pkg::OPB_TIME: opb = BW'(t_q);
			default:           opb = u_q;
		endcase
		case (add_q)
			qmj_pkg::ADD_A:   addend = a_q;
			qmj_pkg::ADD_B:   addend = b_q;
			qmj_pkg::ADD_2V0: addend = DW'(v0_q) <<< 1;
			qmj_pkg::ADD_2S0: addend = DW'(s0_q) <<< 1;
			default:          addend = '0;
		endcase
	end

	assign wres = mres + addend;

	qmj_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (opa),
		.b      (opb),
		.mode   (cmd.mode),
		.res    (mres),
		.done   (mdone)
	);

	qmj_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.t      (t_q),
		.d      (d_q),
		.q      (dq),
		.done   (ddone)
	);

	// final halving with round half up, then clamp to the 32-bit range
	assign sum  = p2_q + acc_q;
	assign rsum = (sum + DW'(1)) >>> 1;
	assign pos_sat = (rsum > qmj_pkg::POS_MAX) ? 32'sh7fffffff :
		(rsum < qmj_pkg::POS_MIN) ? 32'sh80000000 : rsum[31:0];

	assign t_last   = (d_q[15:10] > LAST_CAP) ? LAST_CAP : d_q[15:10];
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s0_q <= start_pos;
			v0_q <= start_vel;
			a0_q <= start_acc;
			s1_q <= end_pos;
			v1_q <= end_vel;
			a1_q <= end_acc;
			d_q  <= duration;
		end
		if (cmd.mul_go) begin
			dst_q <= cmd.dst;
			add_q <= cmd.add;
		end
		if (mdone) begin
			case (dst_q)
				qmj_pkg::DST_AT:   at_q   <= wres;
				qmj_pkg::DST_ATT:  att_q  <= wres;
				qmj_pkg::DST_VT:   vt_q   <= wres;
				qmj_pkg::DST_DVT:  dvt_q  <= wres;
				qmj_pkg::DST_DAT:  dat_q  <= wres;
				qmj_pkg::DST_DATT: datt_q <= wres;
				qmj_pkg::DST_ACC:  acc_q  <= wres;
				default:           p2_q   <= wres;
			endcase
		end
		if (cmd.form_h)
			h_q <= DW'(s1_q) - DW'(s0_q) - vt_q - att_q;
		if (cmd.form_coef) begin
			a_q <= h_q * DW'(20) - dvt_q * DW'(8) + datt_q;
			b_q <= dvt_q * DW'(14) - h_q * DW'(30) - (datt_q <<< 1);
			c_q <= h_q * DW'(12) - dvt_q * DW'(6) + datt_q;
		end
		if (ddone)
			u_q <= (t_q == '0) ? '0 : dq;
		if (cmd.emit) begin
			out_time_q <= t_q;
			out_pos_q  <= pos_sat;
			out_last_q <= t_q == t_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				t_q <= '0;
			else if (cmd.emit)
				t_q <= t_q + TW'(1);
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.mul_done    = mdone;
	assign sts.div_done    = ddone;
	assign sts.out_free    = out_free;
	assign sts.last_sample = t_q == t_last;

	assign out_valid   = out_valid_q;
	assign sample_time = out_time_q;
	assign position    = out_pos_q;
	assign last        = out_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result register loaded while a sample still waits");

endmodule

// ===== rtl/qmj_ctrl.sv =====
// controller: sequences the solve and the per-sample evaluation
module qmj_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  qmj_pkg::sts_t sts,
	output qmj_pkg::cmd_t cmd
);

	localparam int SW = qmj_pkg::STEPW;
	localparam logic [SW-1:0] STEP_SOLVE_END = SW'(5);
	localparam logic [SW-1:0] STEP_SAMPLE    = SW'(6);
	localparam logic [SW-1:0] STEP_P2_END    = SW'(7);
	localparam logic [SW-1:0] STEP_END       = SW'(12);

	qmj_pkg::state_t state_q, state_d;
	logic [SW-1:0]   step_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qmj_pkg::ST_IDLE:
				if (in_valid)
					state_d = qmj_pkg::ST_MUL_GO;
			qmj_pkg::ST_MUL_GO:
				state_d = qmj_pkg::ST_MUL_WAIT;
			qmj_pkg::ST_MUL_WAIT:
				if (sts.mul_done) begin
					if (step_q == STEP_SOLVE_END)
						state_d = qmj_pkg::ST_FORM_H;
					else if (step_q == STEP_P2_END)
						state_d = qmj_pkg::ST_DIV_GO;
					else if (step_q == STEP_END)
						state_d = qmj_pkg::ST_EMIT;
					else
						state_d = qmj_pkg::ST_MUL_GO;
				end
			qmj_pkg::ST_FORM_H:
				state_d = qmj_pkg::ST_FORM_COEF;
			qmj_pkg::ST_FORM_COEF:
				state_d = qmj_pkg::ST_MUL_GO;
			qmj_pkg::ST_DIV_GO:
				state_d = qmj_pkg::ST_DIV_WAIT;
			qmj_pkg::ST_DIV_WAIT:
				if (sts.div_done)
					state_d = qmj_pkg::ST_MUL_GO;
			qmj_pkg::ST_EMIT:
				if (sts.out_free)
					state_d = sts.last_sample ? qmj_pkg::ST_IDLE : qmj_pkg::ST_MUL_GO;
			default:
				state_d = qmj_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == qmj_pkg::ST_IDLE) && in_valid;
		cmd.mul_go    = state_q == qmj_pkg::ST_MUL_GO;
		cmd.form_h    = state_q == qmj_pkg::ST_FORM_H;
		cmd.form_coef = state_q == qmj_pkg::ST_FORM_COEF;
		cmd.div_go    = state_q == qmj_pkg::ST_DIV_GO;
		cmd.emit      = (state_q == qmj_pkg::ST_EMIT) && sts.out_free;
		cmd.opa       = qmj_pkg::OPA_ACC;
		cmd.opb       = qmj_pkg::OPB_U;
		cmd.mode      = qmj_pkg::RND_MQ;
		cmd.dst       = qmj_pkg::DST_ACC;
		cmd.add       = qmj_pkg::ADD_NONE;
		unique case (step_q)
			4'd0: begin
				cmd.opa = qmj_pkg::OPA_A0;  cmd.opb = qmj_pkg::OPB_DUR;
				cmd.mode = qmj_pkg::RND_10; cmd.dst = qmj_pkg::DST_AT;
			end
			4'd1: begin
				cmd.opa = qmj_pkg::OPA_AT;  cmd.opb = qmj_pkg::OPB_DUR;
				cmd.mode = qmj_pkg::RND_11; cmd.dst = qmj_pkg::DST_ATT;
			end
			4'd2: begin
				cmd.opa = qmj_pkg::OPA_V0;  cmd.opb = qmj_pkg::OPB_DUR;
				cmd.mode = qmj_pkg::RND_10; cmd.dst = qmj_pkg::DST_VT;
			end
			4'd3: begin
				cmd.opa = qmj_pkg::OPA_DV;  cmd.opb = qmj_pkg::OPB_DUR;
				cmd.mode = qmj_pkg::RND_10; cmd.dst = qmj_pkg::DST_DVT;
			end
			4'd4: begin
				cmd.opa = qmj_pkg::OPA_DA;  cmd.opb = qmj_pkg::OPB_DUR;
				cmd.mode = qmj_pkg::RND_10; cmd.dst = qmj_pkg::DST_DAT;
			end
			4'd5: begin
				cmd.opa = qmj_pkg::OPA_DAT; cmd.opb = qmj_pkg::OPB_DUR;
				cmd.mode = qmj_pkg::RND_10; cmd.dst = qmj_pkg::DST_DATT;
			end
			4'd6: begin
				cmd.opa = qmj_pkg::OPA_A0;    cmd.opb = qmj_pkg::OPB_TIME;
				cmd.mode = qmj_pkg::RND_NONE; cmd.add = qmj_pkg::ADD_2V0;
			end
			4'd7: begin
				cmd.opb = qmj_pkg::OPB_TIME;  cmd.mode = qmj_pkg::RND_NONE;
				cmd.dst = qmj_pkg::DST_P2;    cmd.add = qmj_pkg::ADD_2S0;
			end
			4'd8: begin
				cmd.opa = qmj_pkg::OPA_C; cmd.add = qmj_pkg::ADD_B;
			end
			4'd9:
				cmd.add = qmj_pkg::ADD_A;
			default:
				cmd.add = qmj_pkg::ADD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qmj_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				step_q <= '0;
			else if (state_q == qmj_pkg::ST_MUL_WAIT && sts.mul_done)
				step_q <= step_q + SW'(1);
			else if (cmd.emit)
				step_q <= STEP_SAMPLE;
		end
	end

	assign in_stall = state_q != qmj_pkg::ST_IDLE;

	a_mul_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> state_q == qmj_pkg::ST_MUL_WAIT)
		else $error("multiplier result arrived outside a wait");

	a_div_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == qmj_pkg::ST_DIV_WAIT)
		else $error("divider result arrived outside a wait");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == qmj_pkg::ST_MUL_GO |-> step_q <= STEP_END)
		else $error("micro-step beyond the end of the sequence");

endmodule

// ===== rtl/quintic_min_jerk_trajectory_unit.sv =====
// top level of the quintic minimum-jerk trajectory unit
// one transfer in gives the start and end state of one axis plus a duration T
// (Q16.16 values, Q6.10 duration); the unit fits the quintic minimum-jerk
// polynomial and then streams its position at t = 0, 1, .. floor(T), capped at
// MAX_SAMPLES samples, with last set on the final one and positions clamped to
// the signed 32-bit range. items are handled one at a time: the input stalls
// from acceptance until the final sample has been loaded into the output
// register. all products by the duration, the sample time or u go through one
// shared two-pass multiplier and the normalised time t/T comes from a
// one-bit-per-cycle divider. the result register lets a finished sample wait
// while the next one is being computed
module quintic_min_jerk_trajectory_unit #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] start_pos,
	input  logic signed [31:0] start_vel,
	input  logic signed [31:0] start_acc,
	input  logic signed [31:0] end_pos,
	input  logic signed [31:0] end_vel,
	input  logic signed [31:0] end_acc,
	input  logic        [15:0] duration,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [5:0]  sample_time,
	output logic signed [31:0] position,
	output logic               last
);

	// command and status between the sequencer and the arithmetic
	qmj_pkg::cmd_t cmd;
	qmj_pkg::sts_t sts;

	qmj_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath holds the item, the solved coefficients and the result register
	qmj_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.start_pos   (start_pos),
		.start_vel   (start_vel),
		.start_acc   (start_acc),
		.end_pos     (end_pos),
		.end_vel     (end_vel),
		.end_acc     (end_acc),
		.duration    (duration),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_time (sample_time),
		.position    (position),
		.last        (last)
	);

endmodule

// ===== verif/qmj_checker.sv =====
`timescale 1ns / 100ps
// checker: predicts the sampled quintic trajectory and compares every output transfer
module qmj_checker #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] start_pos,
	input  logic signed [31:0] start_vel,
	input  logic signed [31:0] start_acc,
	input  logic signed [31:0] end_pos,
	input  logic signed [31:0] end_vel,
	input  logic signed [31:0] end_acc,
	input  logic        [15:0] duration,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic        [5:0]  sample_time,
	input  logic signed [31:0] position,
	input  logic               last,
	output int                 fail_count,
	output int                 pending
);

	typedef struct {
		logic [5:0]         t;
		logic signed [31:0] pos;
		logic               lst;
	} sample_t;

	sample_t samples_due[$];

	assign pending = samples_due.size();

	function automatic longint round_shift(longint x, int n);
		return (x + (longint'(1) << (n - 1))) >>> n;
	endfunction

	// multiply by u in q2.30, rounded half away from zero
	function automatic longint scale_u(longint a, longint u);
		longint m;
		longint r;
		m = (a < 0) ? -a : a;
		r = (((m & 64'hFFFFFFFF) * u + (longint'(1) << 29)) >> 30) + (m >> 32) * u * 4;
		return (a < 0) ? -r : r;
	endfunction

	task automatic fit_and_sample(longint s0, longint v0, longint a0, longint s1,
		longint v1, longint a1, longint d);
		longint a_t, a_tt, v_t, h, dv, da, dv_t, da_t, da_tt, ca, cb, cc;
		longint u, x, p2, p;
		int n;
		sample_t s;
		a_t   = round_shift(a0 * d, 10);
		a_tt  = round_shift(a_t * d, 11);
		v_t   = round_shift(v0 * d, 10);
		h     = s1 - s0 - v_t - a_tt;
		dv    = v1 - v0 - a_t;
		da    = a1 - a0;
		dv_t  = round_shift(dv * d, 10);
		da_t  = round_shift(da * d, 10);
		da_tt = round_shift(da_t * d, 10);
		ca = 20 * h - 8 * dv_t + da_tt;
		cb = -30 * h + 14 * dv_t - 2 * da_tt;
		cc = 12 * h - 6 * dv_t + da_tt;
		n = int'(d >> 10) + 1;
		if (n > MAX_SAMPLES)
			n = MAX_SAMPLES;
		for (int k = 0; k < n; k++) begin
			x = 0;
			if (d != 0 && k != 0) begin
				u = (longint'(k) << 40) / d;
				x = scale_u(scale_u(scale_u(scale_u(scale_u(cc, u) + cb, u) + ca, u), u), u);
			end
			p2 = 2 * s0 + 2 * v0 * k + a0 * k * k;
			p = round_shift(p2 + x, 1);
			if (p > 64'sd2147483647)
				p = 64'sd2147483647;
			if (p < -64'sd2147483648)
				p = -64'sd2147483648;
			s.t = k[5:0];
			s.pos = p[31:0];
			s.lst = (k == n - 1);
			samples_due = {samples_due, s};
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk) begin
		sample_t e;
		if (arst_n && in_valid && !in_stall)
			fit_and_sample(start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
				longint'(duration));
		if (arst_n && out_valid && !out_stall) begin
			if (samples_due.size() == 0) begin
				$display("%0t: unexpected sample t=%0d pos=%0d last=%0b", $time,
					sample_time, position, last);
				fail_count++;
			end else begin
				e = samples_due.pop_front();
				if (e.t !== sample_time) begin
					$display("%0t: sample_time expected %0d actual %0d", $time, e.t, sample_time);
					fail_count++;
				end
				if (e.pos !== position) begin
					$display("%0t: position expected %0d actual %0d", $time, e.pos, position);
					fail_count++;
				end
				if (e.lst !== last) begin
					$display("%0t: last expected %0b actual %0b", $time, e.lst, last);
					fail_count++;
				end
			end
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// testbench top: stimulus, handshake pacing and the verdict
module tb;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [31:0] start_pos = 0, start_vel = 0, start_acc = 0;
	logic signed [31:0] end_pos = 0, end_vel = 0, end_acc = 0;
	logic        [15:0] duration = 16'd1024;
	logic               out_valid;
	logic               out_stall = 0;
	logic        [5:0]  sample_time;
	logic signed [31:0] position;
	logic               last;
	int                 fail_count;
	int                 pending;
	longint             cycle_count = 0;

	// generous: room for ~420 items even if all ran 64 samples
	localparam longint CYCLE_LIMIT = 12000000;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	quintic_min_jerk_trajectory_unit DUT (.*);

	qmj_checker checker_i (.*);

	// receiver stall pattern: alternates calm and busy stretches
	int stall_mode = 0;
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7)) inside
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($urandom_range(0, 1) ? 1 : -1) * 32'($urandom_range(0, 20) << 16);
			3, 4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	// mostly short manoeuvres, a few up to the full duration range
	function automatic logic [15:0] pick_duration();
		case ($urandom_range(0, 19))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 1023));
			default: return 16'($urandom_range(1, 8 * 1024));
		endcase
	endfunction

	// one input transfer, held until accepted
	task automatic send(logic [31:0] s0, v0, a0, s1, v1, a1, logic [15:0] d);
		start_pos <= s0; start_vel <= v0; start_acc <= a0;
		end_pos <= s1; end_vel <= v1; end_acc <= a1;
		duration <= d;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic gap(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	int burst;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero duration, sample cap, extremes, saturation
		send(32'h00010000, 32'h00020000, 32'h00030000, 32'h00050000, 0, 0, 16'd0);
		send(0, 0, 0, 0, 0, 0, 16'd1);
		send(32'h00010000, 0, 0, 32'h000A0000, 0, 0, 16'd1024);
		send(0, 32'h00010000, 0, 32'h00100000, 32'h00010000, 0, 16'd5120);
		send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			32'h80000000, 16'hFFFF);
		send(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 16'hFFFF);
		send(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 16'd3072);
		send(32'h80000000, 32'h80000000, 0, 32'h80000000, 0, 32'h80000000, 16'd2048);
		send(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'hFFFFFFFF, 16'd64511);
		send(0, 0, 0, 32'h00640000, 0, 0, 16'd65535);
		send(32'h12345678, 32'hFEDCBA98, 32'h00008000, 32'hA5A5A5A5, 32'h5A5A5A5A,
			32'hFFFF0000, 16'd1023);
		drain();

		// random bursts with random gaps
		for (int i = 0; i < 400; i += burst) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++)
				send(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
					pick_value(), pick_duration());
			if (i > 200 && i < 215)
				drain();
			else
				gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 40));
		end
		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
